FILE: hw/rtl/soes_pkg.sv
// shared types, constants and helpers of the selection outline stencil
`default_nettype none

package soes_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WIDTH_W    = 12;
    localparam int COLOR_W    = 32;
    localparam int DEPTH_W    = 16;
    localparam int MARGIN_W   = 15;

    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [COLOR_W-1:0]  EDGE_COLOR_RST   = 32'hFF00_7BFF;
    localparam logic [MARGIN_W-1:0] DEPTH_MARGIN_RST = 15'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_EDGE_COLOR   = 2'd1,
        CFG_DEPTH_MARGIN = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } t_action;

    // one classified item on its way from the front to the back
    typedef struct packed {
        logic                      emit;
        logic                      we;
        logic                      done;
        logic                      has_left;
        logic                      has_right;
        logic                      has_upper;
        logic                      has_lower;
        logic signed [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0]        color;
    } t_job;

    // one column of the line memory
    typedef struct packed {
        logic [COLOR_W-1:0]        color;
        logic signed [DEPTH_W-1:0] prev;
        logic signed [DEPTH_W-1:0] upper;
    } t_line;

    // unselected neighbor deeper than center minus margin
    function automatic logic f_hit(
        input logic signed [DEPTH_W-1:0] nb,
        input logic signed [DEPTH_W-1:0] center,
        input logic [MARGIN_W-1:0]       margin
    );
        logic signed [DEPTH_W+1:0] mag;
        logic signed [DEPTH_W+1:0] thr;
        mag = -((DEPTH_W+2)'(nb));
        thr = (DEPTH_W+2)'(center) - $signed({3'b000, margin});
        return nb[DEPTH_W-1] && (mag > thr);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/selection_outline_edge_stencil_top.sv
// top level of the selection outline stencil
// throughput: one pixel or drain transaction per clock unless the queue is full
// or a result is held at the output; set by the line memory (two read ports and
// one write port, one column each per cycle)
// path of a result: queue, memory read, neighbor test into the output register
// reset: synchronous, clears counters, queue and valid flags; the line memory
// is not cleared and needs no clearing pass
`default_nettype none

module selection_outline_edge_stencil_top #(
    parameter int  MAX_WIDTH = soes_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration transactions
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [soes_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [soes_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input transactions
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_action,
    input  wire logic signed [soes_pkg::DEPTH_W-1:0] i_mask_depth,
    input  wire logic [soes_pkg::COLOR_W-1:0]        i_base_color,
    // result transactions
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [soes_pkg::COLOR_W-1:0]             o_out_color,
    output logic                                     o_is_edge,
    output logic                                     o_frame_done
);
    import soes_pkg::*;

    // front to queue
    logic              push;
    t_job              push_job;
    logic [ADDR_W-1:0] push_col;
    logic              q_full;

    // queue to back
    logic              q_valid;
    logic              q_pop;
    t_job              q_job;
    logic [ADDR_W-1:0] q_col;

    // configuration seen by the back
    logic [COLOR_W-1:0]  edge_color;
    logic [MARGIN_W-1:0] depth_margin;

    // front: registers, column and row counters, drops items that give
    // nothing and tags the rest with their neighbor set
    soes_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_mask_depth   (i_mask_depth),
        .i_base_color   (i_base_color),
        .o_push         (push),
        .o_job          (push_job),
        .o_col          (push_col),
        .i_full         (q_full),
        .o_edge_color   (edge_color),
        .o_depth_margin (depth_margin)
    );

    // queue lets the front keep taking transactions while a result waits
    soes_queue #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_col   (push_col),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_col   (q_col)
    );

    // back: per column the memory holds the previous row's color and depth
    // and the depth of the row above it; the left neighbor is kept in a register
    soes_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (q_valid),
        .o_pop          (q_pop),
        .i_job          (q_job),
        .i_col          (q_col),
        .i_edge_color   (edge_color),
        .i_depth_margin (depth_margin),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_color    (o_out_color),
        .o_is_edge      (o_is_edge),
        .o_frame_done   (o_frame_done)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/soes_front.sv
// front part: configuration registers, frame counters and item classification
`default_nettype none

module soes_front #(
    parameter int  MAX_WIDTH = soes_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(MAX_WIDTH),
    localparam int CNT_W     = ADDR_W + 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [soes_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [soes_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_action,
    input  wire logic signed [soes_pkg::DEPTH_W-1:0] i_mask_depth,
    input  wire logic [soes_pkg::COLOR_W-1:0]     i_base_color,
    output logic                                  o_push,
    output soes_pkg::t_job                        o_job,
    output logic [ADDR_W-1:0]                     o_col,
    input  wire logic                             i_full,
    output logic [soes_pkg::COLOR_W-1:0]          o_edge_color,
    output logic [soes_pkg::MARGIN_W-1:0]         o_depth_margin
);
    import soes_pkg::*;

    logic [WIDTH_W-1:0]  r_image_width;
    logic [COLOR_W-1:0]  r_edge_color;
    logic [MARGIN_W-1:0] r_depth_margin;
    logic [ADDR_W-1:0]   r_col,   n_col;
    logic [1:0]          r_rows,  n_rows;
    logic [ADDR_W-1:0]   r_drain, n_drain;

    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] col_nxt;
    logic [CNT_W-1:0] drn_nxt;
    logic             last_col;
    logic             last_drn;
    logic             accept;
    logic             cfg_wr;
    logic             keep;
    t_job             job;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_ready     = !i_full;
    assign accept      = i_valid && o_ready;

    // width clamped to the supported range
    always_comb begin
        if (r_image_width < WIDTH_W'(2)) begin
            w_eff = CNT_W'(2);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_image_width);
        end
    end

    assign col_nxt  = {1'b0, r_col} + CNT_W'(1);
    assign drn_nxt  = {1'b0, r_drain} + CNT_W'(1);
    assign last_col = col_nxt >= w_eff;
    assign last_drn = drn_nxt >= w_eff;

    always_comb begin
        keep    = 1'b0;
        job     = '0;
        o_col   = r_col;
        n_col   = r_col;
        n_rows  = r_rows;
        n_drain = r_drain;
        job.depth = i_mask_depth;
        job.color = i_base_color;
        unique case (t_action'(i_action))
            ACT_PIXEL: begin
                keep          = (r_drain == '0);
                job.emit      = (r_rows != 2'd0);
                job.we        = 1'b1;
                job.has_left  = (r_col != '0);
                job.has_right = !last_col;
                job.has_upper = r_rows[1];
                job.has_lower = 1'b1;
                if (accept && keep) begin
                    if (last_col) begin
                        n_col = '0;
                        if (!r_rows[1]) begin
                            n_rows = r_rows + 2'd1;
                        end
                    end else begin
                        n_col = col_nxt[ADDR_W-1:0];
                    end
                end
            end
            ACT_DRAIN: begin
                keep          = (r_rows != 2'd0) && (r_col == '0);
                o_col         = r_drain;
                job.emit      = 1'b1;
                job.done      = last_drn;
                job.has_left  = (r_drain != '0);
                job.has_right = !last_drn;
                job.has_upper = r_rows[1];
                if (accept && keep) begin
                    if (last_drn) begin
                        n_rows  = 2'd0;
                        n_drain = '0;
                    end else begin
                        n_drain = drn_nxt[ADDR_W-1:0];
                    end
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        // a width write restarts the frame
        if (cfg_wr && (i_cfg_index == CFG_IMAGE_WIDTH)) begin
            n_col   = '0;
            n_rows  = 2'd0;
            n_drain = '0;
        end
    end

    assign o_push = accept && keep;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_rows  <= 2'd0;
            r_drain <= '0;
        end else begin
            r_col   <= n_col;
            r_rows  <= n_rows;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_edge_color   <= EDGE_COLOR_RST;
            r_depth_margin <= DEPTH_MARGIN_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_EDGE_COLOR:   r_edge_color   <= i_cfg_data[COLOR_W-1:0];
                CFG_DEPTH_MARGIN: r_depth_margin <= i_cfg_data[MARGIN_W-1:0];
                default: begin
                    r_image_width <= r_image_width;
                end
            endcase
        end
    end

    assign o_edge_color   = r_edge_color;
    assign o_depth_margin = r_depth_margin;

endmodule

`default_nettype wire

FILE: hw/rtl/soes_queue.sv
// short queue of classified items between front and back
`default_nettype none

module soes_queue #(
    parameter int  MAX_WIDTH = soes_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  soes_pkg::t_job         i_job,
    input  wire logic [ADDR_W-1:0] i_col,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output soes_pkg::t_job         o_job,
    output logic [ADDR_W-1:0]      o_col
);
    import soes_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_job [QUEUE_DEPTH];
    logic [ADDR_W-1:0] r_colq [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_job[r_rd_ptr];
    assign o_col   = r_colq[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_job[r_wr_ptr]  <= i_job;
            r_colq[r_wr_ptr] <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/soes_back.sv
// back part: line memory, neighbor test and output register
`default_nettype none

module soes_back #(
    parameter int  MAX_WIDTH = soes_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_pop_valid,
    output logic                               o_pop,
    input  soes_pkg::t_job                     i_job,
    input  wire logic [ADDR_W-1:0]             i_col,
    input  wire logic [soes_pkg::COLOR_W-1:0]  i_edge_color,
    input  wire logic [soes_pkg::MARGIN_W-1:0] i_depth_margin,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [soes_pkg::COLOR_W-1:0]       o_out_color,
    output logic                               o_is_edge,
    output logic                               o_frame_done
);
    import soes_pkg::*;

    t_line             r_mem [MAX_WIDTH];
    t_line             r_rd0;
    t_line             r_rd1;
    t_line             r_wdat;
    logic              r_fwd0;
    logic              r_fwd1;
    logic              r_a_valid;
    t_job              r_a_job;
    logic [ADDR_W-1:0] r_a_col;
    logic signed [DEPTH_W-1:0] r_left;
    logic              r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic              r_out_edge;
    logic              r_out_done;

    logic              en;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic              wr_en;
    t_line             wr_data;
    t_line             data0;
    t_line             data1;
    logic signed [DEPTH_W-1:0] center;
    logic              edge_hit;

    // whole back advances unless a finished result is held
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_pop_valid;

    assign addr0 = i_col;
    assign addr1 = i_job.has_right ? i_col + ADDR_W'(1) : i_col;

    // read data with bypass of the write in the same cycle
    assign data0  = r_fwd0 ? r_wdat : r_rd0;
    assign data1  = r_fwd1 ? r_wdat : r_rd1;
    assign center = data0.prev;

    always_comb begin
        edge_hit = 1'b0;
        if (!center[DEPTH_W-1] && (center != '0)) begin
            edge_hit = (r_a_job.has_left  && f_hit(r_left, center, i_depth_margin))
                    || (r_a_job.has_right && f_hit(data1.prev, center, i_depth_margin))
                    || (r_a_job.has_upper && f_hit(data0.upper, center, i_depth_margin))
                    || (r_a_job.has_lower && f_hit(r_a_job.depth, center, i_depth_margin));
        end
    end

    assign wr_en         = en && r_a_valid && r_a_job.we;
    assign wr_data.color = r_a_job.color;
    assign wr_data.prev  = r_a_job.depth;
    assign wr_data.upper = center;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_a_col] <= wr_data;
        end
        if (en) begin
            r_rd0 <= r_mem[addr0];
            r_rd1 <= r_mem[addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd0  <= wr_en && (r_a_col == addr0);
            r_fwd1  <= wr_en && (r_a_col == addr1);
            r_wdat  <= wr_data;
            r_a_job <= i_job;
            r_a_col <= i_col;
            if (r_a_valid) begin
                r_left <= center;
            end
            r_out_color <= edge_hit ? i_edge_color : data0.color;
            r_out_edge  <= edge_hit;
            r_out_done  <= r_a_job.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_pop_valid;
            r_out_valid <= r_a_valid && r_a_job.emit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_color  = r_out_color;
    assign o_is_edge    = r_out_edge;
    assign o_frame_done = r_out_done;

endmodule

`default_nettype wire
